// ===== rtl/core/infix_to_postfix_converter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Each macro takes a label, a clock, an active-low reset, a condition and
// the property that must follow from it.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// The consequent must hold in the same cycle as the condition.
`define ITP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itp assertion failed");

// The consequent must hold in the cycle after the condition.
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itp assertion failed");

`endif

// ===== rtl/core/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and helpers shared by the infix to postfix converter files.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  localparam int unsigned StackDepthDefault = 16;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned ValueW = 32;

  // Stack entry code for an open paren; operators use codes zero to three.
  localparam logic [CodeW-1:0] PAREN_CODE = 3'd4;

  typedef enum logic [CmdW-1:0] {
    TOK_NUM   = 3'd0,
    TOK_OP    = 3'd1,
    TOK_OPEN  = 3'd2,
    TOK_CLOSE = 3'd3,
    TOK_END   = 3'd4
  } tok_e;

  typedef enum logic [1:0] {
    KIND_NUM = 2'd0,
    KIND_OP  = 2'd1,
    KIND_ERR = 2'd2,
    KIND_END = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CLOSE    = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_OPEN     = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUM,
    S_READ,
    S_EVAL,
    S_PUSH,
    S_ERROR,
    S_END,
    S_FLUSH
  } state_e;

  // Precedence of a stack code: plus and minus 1, times and divide 2, paren 0.
  function automatic logic [1:0] rank_of(input logic [CodeW-1:0] code);
    logic [1:0] r;
    case (code)
      3'd0, 3'd1: r = 2'd1;
      3'd2, 3'd3: r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from tokenised infix to postfix order.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries one token word: a number,
// an operator, an open or close paren, or end. The output channel
// (out_valid_o / out_ready_i) carries postfix words; last_o marks the final
// word caused by an input token. Errors are sent as words of kind error and
// always leave the operator stack empty.
// One token is worked on at a time and in_ready_o is high only when the
// sequencer is idle. Every stack pop passes through a RAM read state and an
// evaluate state (S_READ, then S_EVAL), since the stack RAM has a single
// read port with registered data.
// Reset empties the stack at once; there is no clearing pass.
// When the receiver stalls, the output register holds its word and one more
// word may wait in a holding register; the sequencer then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = itp_pkg::StackDepthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic        [itp_pkg::CmdW-1:0]   cmd_i,
  input  wire logic signed [itp_pkg::ValueW-1:0] number_value_i,
  input  wire logic        [itp_pkg::OpW-1:0]    operator_code_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic             [1:0]                 out_kind_o,
  output logic signed      [itp_pkg::ValueW-1:0] out_value_o,
  output logic             [itp_pkg::OpW-1:0]    out_operator_o,
  output logic             [1:0]                 error_code_o,
  output logic                                   last_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  itp_pkg::state_e state_q, state_d;
  itp_pkg::tok_e   cmd_q, cmd_d;
  logic [itp_pkg::OpW-1:0]           op_q, op_d;
  logic signed [itp_pkg::ValueW-1:0] val_q, val_d;
  logic [CntW-1:0] count_q, count_d;
  logic            paren_left_q, paren_left_d;
  itp_pkg::err_e   err_q, err_d;

  // Holding register: a word whose last flag is not yet known.
  logic                    pend_valid_q, pend_valid_d;
  itp_pkg::kind_e          pend_kind_q, pend_kind_d;
  logic [itp_pkg::OpW-1:0] pend_op_q, pend_op_d;
  itp_pkg::err_e           pend_err_q, pend_err_d;

  logic                              out_valid_q, out_valid_d;
  itp_pkg::kind_e                    out_kind_q, out_kind_d;
  logic signed [itp_pkg::ValueW-1:0] out_value_q, out_value_d;
  logic [itp_pkg::OpW-1:0]           out_op_q, out_op_d;
  itp_pkg::err_e                     out_err_q, out_err_d;
  logic                              out_last_q, out_last_d;

  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr;
  logic [itp_pkg::CodeW-1:0] ram_wdata;
  logic [AddrW-1:0]         ram_raddr;
  logic [itp_pkg::CodeW-1:0] top;
  logic [CntW-1:0]          count_m1;

  itp_ram #(
    .Width(itp_pkg::CodeW),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(top)
  );

  assign count_m1  = count_q - CntW'(1);
  assign ram_raddr = count_m1[AddrW-1:0];
  assign ram_waddr = count_q[AddrW-1:0];
  assign ram_wdata = (cmd_q == itp_pkg::TOK_OP) ? {1'b0, op_q} : itp_pkg::PAREN_CODE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= itp_pkg::S_IDLE;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    op_q         <= op_d;
    val_q        <= val_d;
    paren_left_q <= paren_left_d;
    err_q        <= err_d;
    pend_kind_q  <= pend_kind_d;
    pend_op_q    <= pend_op_d;
    pend_err_q   <= pend_err_d;
    out_kind_q   <= out_kind_d;
    out_value_q  <= out_value_d;
    out_op_q     <= out_op_d;
    out_err_q    <= out_err_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    logic                              slot_ok;
    logic                              hold_ok;
    logic                              em_req;
    logic                              em_final;
    itp_pkg::kind_e                    em_kind;
    logic signed [itp_pkg::ValueW-1:0] em_value;
    logic [itp_pkg::OpW-1:0]           em_op;
    itp_pkg::err_e                     em_err;
    logic                              fin_req;
    logic                              pop_op;

    slot_ok  = !out_valid_q || out_ready_i;
    // A word that may not be final can go to the holding register whenever
    // the holding register can pass its current word on.
    hold_ok  = !pend_valid_q || slot_ok;
    em_req   = 1'b0;
    em_final = 1'b0;
    em_kind  = itp_pkg::KIND_OP;
    em_value = '0;
    em_op    = top[itp_pkg::OpW-1:0];
    em_err   = itp_pkg::ERR_NONE;
    fin_req  = 1'b0;
    pop_op   = 1'b0;

    state_d      = state_q;
    cmd_d        = cmd_q;
    op_d         = op_q;
    val_d        = val_q;
    count_d      = count_q;
    paren_left_d = paren_left_q;
    err_d        = err_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_op_d    = pend_op_q;
    pend_err_d   = pend_err_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_value_d  = out_value_q;
    out_op_d     = out_op_q;
    out_err_d    = out_err_q;
    out_last_d   = out_last_q;
    in_ready_o   = 1'b0;
    ram_we       = 1'b0;

    unique case (state_q)
      itp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d        = itp_pkg::tok_e'(cmd_i);
          op_d         = operator_code_i;
          val_d        = number_value_i;
          paren_left_d = 1'b0;
          unique case (cmd_i)
            itp_pkg::TOK_NUM: state_d = itp_pkg::S_NUM;
            itp_pkg::TOK_OP: begin
              state_d = (count_q == '0) ? itp_pkg::S_PUSH : itp_pkg::S_READ;
            end
            itp_pkg::TOK_OPEN: state_d = itp_pkg::S_PUSH;
            itp_pkg::TOK_CLOSE: begin
              err_d   = itp_pkg::ERR_CLOSE;
              state_d = (count_q == '0) ? itp_pkg::S_ERROR : itp_pkg::S_READ;
            end
            itp_pkg::TOK_END: begin
              err_d   = itp_pkg::ERR_OPEN;
              state_d = (count_q == '0) ? itp_pkg::S_END : itp_pkg::S_READ;
            end
            default: state_d = itp_pkg::S_IDLE;
          endcase
        end
      end

      itp_pkg::S_NUM: begin
        if (slot_ok) begin
          em_req   = 1'b1;
          em_final = 1'b1;
          em_kind  = itp_pkg::KIND_NUM;
          em_value = val_q;
          em_op    = '0;
          state_d  = itp_pkg::S_IDLE;
        end
      end

      itp_pkg::S_READ: begin
        state_d = itp_pkg::S_EVAL;
      end

      itp_pkg::S_EVAL: begin
        unique case (cmd_q)
          itp_pkg::TOK_OP: begin
            if (itp_pkg::rank_of(top) >= itp_pkg::rank_of({1'b0, op_q})) begin
              if (hold_ok) begin
                pop_op  = 1'b1;
                count_d = count_m1;
                state_d = (count_q == CntW'(1)) ? itp_pkg::S_PUSH : itp_pkg::S_READ;
              end
            end else begin
              state_d = itp_pkg::S_PUSH;
            end
          end
          itp_pkg::TOK_CLOSE: begin
            if (top == itp_pkg::PAREN_CODE) begin
              if (hold_ok) begin
                fin_req = 1'b1;
                count_d = count_m1;
                state_d = itp_pkg::S_IDLE;
              end
            end else if (hold_ok) begin
              pop_op  = 1'b1;
              count_d = count_m1;
              state_d = (count_q == CntW'(1)) ? itp_pkg::S_ERROR : itp_pkg::S_READ;
            end
          end
          itp_pkg::TOK_END: begin
            if (top == itp_pkg::PAREN_CODE) begin
              paren_left_d = 1'b1;
              count_d      = count_m1;
              state_d      = (count_q == CntW'(1)) ? itp_pkg::S_ERROR : itp_pkg::S_READ;
            end else if (hold_ok) begin
              pop_op  = 1'b1;
              count_d = count_m1;
              if (count_q == CntW'(1)) begin
                state_d = paren_left_q ? itp_pkg::S_ERROR : itp_pkg::S_END;
              end else begin
                state_d = itp_pkg::S_READ;
              end
            end
          end
          default: state_d = itp_pkg::S_IDLE;
        endcase
      end

      itp_pkg::S_PUSH: begin
        if (count_q >= CntW'(STACK_DEPTH)) begin
          if (slot_ok) begin
            em_req   = 1'b1;
            em_final = 1'b1;
            em_kind  = itp_pkg::KIND_ERR;
            em_op    = '0;
            em_err   = itp_pkg::ERR_OVERFLOW;
            count_d  = '0;
            state_d  = pend_valid_q ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
          end
        end else if (hold_ok) begin
          ram_we  = 1'b1;
          count_d = count_q + CntW'(1);
          fin_req = 1'b1;
          state_d = itp_pkg::S_IDLE;
        end
      end

      itp_pkg::S_ERROR: begin
        // At end the open paren error is followed by the end marker.
        if (cmd_q == itp_pkg::TOK_END) begin
          if (hold_ok) begin
            em_req  = 1'b1;
            em_kind = itp_pkg::KIND_ERR;
            em_op   = '0;
            em_err  = err_q;
            state_d = itp_pkg::S_END;
          end
        end else if (slot_ok) begin
          em_req   = 1'b1;
          em_final = 1'b1;
          em_kind  = itp_pkg::KIND_ERR;
          em_op    = '0;
          em_err   = err_q;
          count_d  = '0;
          state_d  = pend_valid_q ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
        end
      end

      itp_pkg::S_END: begin
        if (slot_ok) begin
          em_req   = 1'b1;
          em_final = 1'b1;
          em_kind  = itp_pkg::KIND_END;
          em_op    = '0;
          count_d  = '0;
          state_d  = pend_valid_q ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
        end
      end

      itp_pkg::S_FLUSH: begin
        if (slot_ok) begin
          fin_req = 1'b1;
          state_d = itp_pkg::S_IDLE;
        end
      end

      default: state_d = itp_pkg::S_IDLE;
    endcase

    if (pop_op) begin
      em_req  = 1'b1;
      em_kind = itp_pkg::KIND_OP;
      em_op   = top[itp_pkg::OpW-1:0];
    end

    // Word movement: holding register to output, new word to output or hold.
    if ((em_req || fin_req) && pend_valid_q) begin
      out_valid_d  = 1'b1;
      out_kind_d   = pend_kind_q;
      out_value_d  = '0;
      out_op_d     = pend_op_q;
      out_err_d    = pend_err_q;
      out_last_d   = fin_req;
      pend_valid_d = 1'b0;
    end
    if (em_req) begin
      if (em_final && !pend_valid_q) begin
        out_valid_d = 1'b1;
        out_kind_d  = em_kind;
        out_value_d = em_value;
        out_op_d    = em_op;
        out_err_d   = em_err;
        out_last_d  = 1'b1;
      end else begin
        pend_valid_d = 1'b1;
        pend_kind_d  = em_kind;
        pend_op_d    = em_op;
        pend_err_d   = em_err;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_value_o    = out_value_q;
  assign out_operator_o = out_op_q;
  assign error_code_o   = out_err_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/itp_ram.sv =====
// ----------------------------------------------------------------------------
// itp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/itp_checker.sv =====
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks for the infix to postfix converter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "infix_to_postfix_converter_macros.svh"

module itp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic        [itp_pkg::CmdW-1:0]   cmd_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic        [1:0]                 out_kind_o,
  input wire logic signed [itp_pkg::ValueW-1:0] out_value_o,
  input wire logic        [itp_pkg::OpW-1:0]    out_operator_o,
  input wire logic        [1:0]                 error_code_o,
  input wire logic                              last_o
);

  // A stalled output word must hold.
  `ITP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_kind_o) && $stable(out_value_o) && $stable(out_operator_o) && $stable(error_code_o) && $stable(last_o))

  // A known token keeps the block busy for at least the next cycle.
  `ITP_ASSERT_NEXT(a_busy_after_token, clk_i, rst_ni, in_valid_i && in_ready_o && (cmd_i <= itp_pkg::CmdW'(itp_pkg::TOK_END)), !in_ready_o)

  // Only number words carry a value.
  `ITP_ASSERT_SAME(a_value_only_num, clk_i, rst_ni, out_valid_o && (out_kind_o != itp_pkg::KIND_NUM), out_value_o == '0)

  // An error code is present exactly on error words.
  `ITP_ASSERT_SAME(a_err_code_kind, clk_i, rst_ni, out_valid_o, (out_kind_o == itp_pkg::KIND_ERR) == (error_code_o != itp_pkg::ERR_NONE))

  // The end marker is always the final word of its token.
  `ITP_ASSERT_SAME(a_end_last, clk_i, rst_ni, out_valid_o && (out_kind_o == itp_pkg::KIND_END), last_o)

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

`default_nettype wire
